// File: rtl/spdp_pkg.sv
// ----------------------------------------------------------------------------
// spdp_pkg: shared types and constants of the pll divider programmer
// constants of the frequency plan, register map and the plan record
// ----------------------------------------------------------------------------
package spdp_pkg;

  localparam logic [29:0] VCO_MAX_HZ  = 30'd900000000;
  localparam logic [19:0] FRAC_DENOM  = 20'd1048575;
  localparam logic [27:0] FREQ_MIN    = 28'd1000000;
  localparam logic [27:0] FREQ_MAX    = 28'd150000000;
  localparam logic [25:0] XTAL_MIN    = 26'd10000000;
  localparam logic [25:0] XTAL_MAX    = 26'd40000000;
  localparam logic [25:0] XTAL_RESET  = 26'd25000000;
  localparam logic [17:0] P1_OFFSET   = 18'd512;

  localparam logic [7:0] CLK_CTRL_BASE = 8'h4C;
  localparam logic [7:0] SRC_PLL_B     = 8'h20;
  localparam logic [7:0] INIT_REG      = 8'd183;
  localparam logic [7:0] INIT_VAL      = 8'hC0;
  localparam logic [7:0] PLL_A_BASE    = 8'd26;
  localparam logic [7:0] PLL_B_BASE    = 8'd34;
  localparam logic [7:0] MS2_BASE      = 8'd58;
  localparam logic [7:0] MS1_BASE      = 8'd50;
  localparam logic [7:0] CLK2_REG      = 8'd18;
  localparam logic [7:0] CLK1_REG      = 8'd17;

  // positions in the write sequence
  localparam logic [4:0] SEQ_INIT      = 5'd0;
  localparam logic [4:0] SEQ_PLL_FIRST = 5'd1;
  localparam logic [4:0] SEQ_MS_FIRST  = 5'd9;
  localparam logic [4:0] SEQ_CLK       = 5'd17;

  // divider step counts for each division
  localparam logic [2:0] DIV1_CYCLES = 3'd3;
  localparam logic [2:0] DIV2_CYCLES = 3'd2;
  localparam logic [2:0] DIV3_CYCLES = 3'd5;
  localparam int         BITS_PER_CYCLE = 4;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic        bfo;
    logic [17:0] p1;
    logic [19:0] p2;
    logic [17:0] m1;
  } spdp_plan_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV1,
    F_MUL,
    F_LD2,
    F_DIV2,
    F_DIV3,
    F_FIN
  } spdp_front_e;

endpackage

// File: rtl/spdp_divider.sv
// ----------------------------------------------------------------------------
// spdp_divider: shared restoring divider
// four quotient bits per cycle, preloaded partial remainder
// ----------------------------------------------------------------------------
module spdp_divider import spdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] rem_init_i,
  input  logic [19:0] low_i,
  input  logic [2:0]  cycles_i,
  input  logic [27:0] divisor_i,
  output logic [19:0] quotient_o,
  output logic [27:0] remainder_o,
  output logic        done_o
);

  logic [28:0] r_q, r_d;
  logic [19:0] low_q, low_d;
  logic [19:0] quot_q, quot_d;
  logic [27:0] d_q;
  logic [2:0]  cnt_q;
  logic        done_q;

  always_comb begin
    r_d    = r_q;
    low_d  = low_q;
    quot_d = quot_q;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r_d   = {r_d[27:0], low_d[19]};
      low_d = {low_d[18:0], 1'b0};
      if (r_d >= {1'b0, d_q}) begin
        r_d    = r_d - {1'b0, d_q};
        quot_d = {quot_d[18:0], 1'b1};
      end else begin
        quot_d = {quot_d[18:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= cycles_i;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 3'd1;
        if (cnt_q == 3'd1) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= rem_init_i;
      low_q  <= low_i;
      quot_q <= '0;
      d_q    <= divisor_i;
    end else if (cnt_q != '0) begin
      r_q    <= r_d;
      low_q  <= low_d;
      quot_q <= quot_d;
    end
  end

  assign quotient_o  = quot_q;
  assign remainder_o = r_q[27:0];
  assign done_o      = done_q;

endmodule

// File: rtl/spdp_front.sv
// ----------------------------------------------------------------------------
// spdp_front: request intake and frequency plan
// clamps inputs, runs the three divisions and packs the pll words
// ----------------------------------------------------------------------------
module spdp_front import spdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        operation_i,
  input  logic [27:0] target_frequency_i,
  input  logic [25:0] xtal_i,
  input  logic        full_i,
  output logic        busy_o,
  output logic        push_o,
  output spdp_plan_t  plan_o
);

  localparam logic [28:0] VCO_HI = 29'(VCO_MAX_HZ >> 12);

  spdp_front_e state_q, state_d;
  logic        bfo_q;
  logic [27:0] f_q;
  logic [25:0] x_q;
  logic [9:0]  div_q;
  logic [29:0] pll_q;
  logic [6:0]  mult_q;
  logic [19:0] num_q;

  logic [27:0] f_clamp;
  logic [25:0] x_clamp;
  logic        dv_start;
  logic [28:0] dv_rinit;
  logic [19:0] dv_low;
  logic [2:0]  dv_cycles;
  logic [27:0] dv_divisor;
  logic [19:0] dv_quot;
  logic [27:0] dv_rem;
  logic        dv_done;
  logic [45:0] frac_dvd;

  logic [26:0] t;
  logic [6:0]  q0;
  logic [20:0] s;
  logic        c;
  logic [6:0]  q;

  spdp_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dv_start),
    .rem_init_i  (dv_rinit),
    .low_i       (dv_low),
    .cycles_i    (dv_cycles),
    .divisor_i   (dv_divisor),
    .quotient_o  (dv_quot),
    .remainder_o (dv_rem),
    .done_o      (dv_done)
  );

  always_comb begin
    f_clamp = target_frequency_i;
    if (f_clamp < FREQ_MIN) f_clamp = FREQ_MIN;
    if (f_clamp > FREQ_MAX) f_clamp = FREQ_MAX;
    x_clamp = xtal_i;
    if (x_clamp < XTAL_MIN) x_clamp = XTAL_MIN;
    if (x_clamp > XTAL_MAX) x_clamp = XTAL_MAX;
    frac_dvd = {dv_rem[25:0], 20'b0} - {20'b0, dv_rem[25:0]};
  end

  always_comb begin
    state_d    = state_q;
    dv_start   = 1'b0;
    dv_rinit   = '0;
    dv_low     = '0;
    dv_cycles  = '0;
    dv_divisor = {2'b0, x_q};
    push_o     = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          dv_start   = 1'b1;
          dv_rinit   = VCO_HI;
          dv_low     = {VCO_MAX_HZ[11:0], 8'b0};
          dv_cycles  = DIV1_CYCLES;
          dv_divisor = f_clamp;
          state_d    = F_DIV1;
        end
      end
      F_DIV1: if (dv_done) state_d = F_MUL;
      F_MUL:  state_d = F_LD2;
      F_LD2: begin
        dv_start  = 1'b1;
        dv_rinit  = {7'b0, pll_q[29:8]};
        dv_low    = {pll_q[7:0], 12'b0};
        dv_cycles = DIV2_CYCLES;
        state_d   = F_DIV2;
      end
      F_DIV2: begin
        if (dv_done) begin
          dv_start  = 1'b1;
          dv_rinit  = {3'b0, frac_dvd[45:20]};
          dv_low    = frac_dvd[19:0];
          dv_cycles = DIV3_CYCLES;
          state_d   = F_DIV3;
        end
      end
      F_DIV3: if (dv_done) state_d = F_FIN;
      F_FIN: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      bfo_q <= operation_i;
      f_q   <= f_clamp;
      x_q   <= x_clamp;
    end
    // divider rounded down to even
    if (state_q == F_DIV1 && dv_done) div_q <= {dv_quot[9:1], 1'b0};
    if (state_q == F_MUL) pll_q <= 30'(div_q * f_q);
    if (state_q == F_DIV2 && dv_done) mult_q <= dv_quot[6:0];
    if (state_q == F_DIV3 && dv_done) num_q <= dv_quot;
  end

  // q = floor(128*num / (2^20-1)) via shift plus one correction
  always_comb begin
    t  = {num_q, 7'b0};
    q0 = t[26:20];
    s  = {1'b0, t[19:0]} + {14'b0, q0};
    c  = (s >= {1'b0, FRAC_DENOM});
    q  = q0 + {6'b0, c};
    plan_o.bfo = bfo_q;
    plan_o.p2  = c ? 20'(s - {1'b0, FRAC_DENOM}) : s[19:0];
    plan_o.p1  = {4'b0, mult_q, 7'b0} + {11'b0, q} - P1_OFFSET;
    plan_o.m1  = {1'b0, div_q, 7'b0} - P1_OFFSET;
  end

  assign busy_o = (state_q != F_IDLE);

endmodule

// File: rtl/spdp_fifo.sv
// ----------------------------------------------------------------------------
// spdp_fifo: plan queue between front and back
// small register queue of packed plan records
// ----------------------------------------------------------------------------
module spdp_fifo import spdp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  spdp_plan_t data_i,
  input  logic       pop_i,
  output spdp_plan_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  spdp_plan_t      mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
      if (pop_i)  rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));

endmodule

// File: rtl/spdp_back.sv
// ----------------------------------------------------------------------------
// spdp_back: register write sequencer
// walks the write list of the queue head, one write per cycle
// ----------------------------------------------------------------------------
module spdp_back import spdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spdp_plan_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       strobe_o,
  output logic [7:0] reg_address_o,
  output logic [7:0] reg_data_o,
  output logic       last_write_o
);

  logic [4:0] seq_q, seq_d;
  logic [4:0] e;
  logic [2:0] i;
  logic [7:0] addr, data;
  logic       strobe_q;
  logic [7:0] addr_q, data_q;
  logic       last_q;

  always_comb begin
    // lo sequence has no init write
    e = (seq_q == SEQ_INIT && !head_i.bfo) ? SEQ_PLL_FIRST : seq_q;
    i = '0;
    addr = INIT_REG;
    data = INIT_VAL;
    if (e == SEQ_INIT) begin
      addr = INIT_REG;
      data = INIT_VAL;
    end else if (e < SEQ_MS_FIRST) begin
      i    = 3'(e - SEQ_PLL_FIRST);
      addr = (head_i.bfo ? PLL_B_BASE : PLL_A_BASE) + {5'b0, i};
      case (i)
        3'd0:    data = FRAC_DENOM[15:8];
        3'd1:    data = FRAC_DENOM[7:0];
        3'd2:    data = {6'b0, head_i.p1[17:16]};
        3'd3:    data = head_i.p1[15:8];
        3'd4:    data = head_i.p1[7:0];
        3'd5:    data = {FRAC_DENOM[19:16], head_i.p2[19:16]};
        3'd6:    data = head_i.p2[15:8];
        default: data = head_i.p2[7:0];
      endcase
    end else if (e < SEQ_CLK) begin
      i    = 3'(e - SEQ_MS_FIRST);
      addr = (head_i.bfo ? MS1_BASE : MS2_BASE) + {5'b0, i};
      case (i)
        3'd1:    data = 8'd1;
        3'd2:    data = {6'b0, head_i.m1[17:16]};
        3'd3:    data = head_i.m1[15:8];
        3'd4:    data = head_i.m1[7:0];
        default: data = 8'd0;
      endcase
    end else begin
      addr = head_i.bfo ? CLK1_REG : CLK2_REG;
      data = head_i.bfo ? (CLK_CTRL_BASE | SRC_PLL_B) : CLK_CTRL_BASE;
    end
    pop_o = !empty_i && (e == SEQ_CLK);
    seq_d = seq_q;
    if (!empty_i) seq_d = (e == SEQ_CLK) ? SEQ_INIT : e + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= SEQ_INIT;
      strobe_q <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      strobe_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr;
    data_q <= data;
    last_q <= (e == SEQ_CLK);
  end

  assign strobe_o      = strobe_q;
  assign reg_address_o = addr_q;
  assign reg_data_o    = data_q;
  assign last_write_o  = strobe_q && last_q;

endmodule

// File: rtl/synth_pll_divider_programmer_unit.sv
// ----------------------------------------------------------------------------
// synth_pll_divider_programmer_unit: pll and divider register programmer
// turns a channel and frequency request into a burst of register writes
// ----------------------------------------------------------------------------
// the first write strobe follows the three divisions, the queue push and the output register
// a request emits 18 writes (bfo) or 17 writes (lo), one per cycle
// intake takes a new request only when the front is idle, once the shared divider has run all
// three divisions and the plan is pushed; over many requests the write burst sets the pace
// results are never stalled: the receiver takes every strobe
// reset (async, active low) empties the queue and loads the 25 MHz crystal
module synth_pll_divider_programmer_unit import spdp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request transaction
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [27:0] target_frequency_i,
  // crystal frequency register
  input  logic        xtal_frequency_we_i,
  input  logic [25:0] xtal_frequency_i,
  // write transactions
  output logic        strobe_o,
  output logic [7:0]  reg_address_o,
  output logic [7:0]  reg_data_o,
  output logic        last_write_o
);

  logic [25:0] xtal_q;
  spdp_plan_t  plan, head;
  logic        push, pop, empty, full;

  // configuration register, only to be written by the user while idle (unchecked by the block)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                  xtal_q <= XTAL_RESET;
    else if (xtal_frequency_we_i) xtal_q <= xtal_frequency_i;
  end

  // front: clamp, divide, pack
  spdp_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .operation_i        (operation_i),
    .target_frequency_i (target_frequency_i),
    .xtal_i             (xtal_q),
    .full_i             (full),
    .busy_o             (busy),
    .push_o             (push),
    .plan_o             (plan)
  );

  // queue lets the front work ahead of the write burst
  spdp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (plan),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  // back: stream the write list
  spdp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .strobe_o      (strobe_o),
    .reg_address_o (reg_address_o),
    .reg_data_o    (reg_data_o),
    .last_write_o  (last_write_o)
  );

endmodule

// File: rtl/spdp_checker.sv
// ----------------------------------------------------------------------------
// spdp_checker: port level checks of the programmer
// write burst shape and request intake
// ----------------------------------------------------------------------------
module spdp_checker import spdp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       strobe_o,
  input logic [7:0] reg_address_o,
  input logic [7:0] reg_data_o,
  input logic       last_write_o
);

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_write_o |-> strobe_o) else $error("last write without strobe");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("not busy after accepted request");

  a_init_then_pll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && reg_address_o == INIT_REG |->
      reg_data_o == INIT_VAL && !last_write_o ##1 strobe_o && reg_address_o == PLL_B_BASE)
    else $error("init write not followed by pll b block");

  a_last_is_clk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_write_o |-> reg_address_o == CLK1_REG || reg_address_o == CLK2_REG)
    else $error("last write is not clock control");

endmodule

bind synth_pll_divider_programmer_unit spdp_checker u_spdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .strobe_o      (strobe_o),
  .reg_address_o (reg_address_o),
  .reg_data_o    (reg_data_o),
  .last_write_o  (last_write_o)
);
